@@ hw/rtl/csb_pkg.sv @@
// ----------------------------------------------------------------------------
// csb_pkg
// Shared widths, codes and record types of the channel scale/bias layer.
// ----------------------------------------------------------------------------
`default_nettype none

package csb_pkg;

  localparam int CHANNELS    = 256;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int SG_W        = 48;
  localparam int BG_W        = 40;
  localparam int POS_W       = 16;
  localparam int CC_W        = 9;
  localparam int SIZE_W      = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int ROUND_SHIFT = 12;
  localparam int ROUND_HALF  = 2048;
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FORWARD  = 2'd1,
    OP_BACKWARD = 2'd2,
    OP_READ     = 2'd3
  } csb_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_INNER_SIZE    = 3'd1,
    REG_OUTER_COUNT   = 3'd2,
    REG_USE_BIAS      = 3'd3,
    REG_PARAM_GRAD    = 3'd4,
    REG_INPUT_GRAD    = 3'd5
  } csb_reg_t;

  // Last valid position of each counter (clamped size minus one)
  typedef struct packed {
    logic [CH_W-1:0]  nch_m1;
    logic [POS_W-1:0] nin_m1;
    logic [POS_W-1:0] nout_m1;
  } csb_limits_t;

  typedef struct packed {
    logic signed [SG_W-1:0] s;
    logic signed [BG_W-1:0] b;
  } csb_sums_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic signed [SG_W-1:0]   scale_grad;
    logic signed [BG_W-1:0]   bias_grad;
    logic [CH_W-1:0]          channel_out;
    logic                     last_of_pass;
    logic                     saturated;
  } csb_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/csb_ram.sv @@
// ----------------------------------------------------------------------------
// csb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csb_position.sv @@
// ----------------------------------------------------------------------------
// csb_position
// Inner/channel/outer position counters, plus a bit-serial remainder pass
// that folds the channel position into a newly written channel count.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_position (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      sop,
  input  logic                      step,
  input  logic                      reduce_start,
  input  csb_pkg::csb_limits_t      limits,
  output logic [csb_pkg::CH_W-1:0]  chan,
  output logic                      last,
  output logic                      busy
);
  import csb_pkg::*;

  localparam int RC_W = $clog2(CH_W);
  localparam logic [RC_W-1:0] CNT_LAST = RC_W'(CH_W - 1);

  logic [POS_W-1:0] inner_pos, inner_eff, inner_next;
  logic [CH_W-1:0]  chan_pos, chan_eff, chan_next;
  logic [POS_W-1:0] outer_pos, outer_eff, outer_next;

  logic [CH_W-1:0]  red_rem;
  logic [CH_W-1:0]  red_div;
  logic [RC_W-1:0]  red_cnt;
  logic [CH_W:0]    red_trial;
  logic [CH_W:0]    red_divisor;
  logic [CH_W:0]    red_step;

  // Start of pass zeroes the counters before this item
  assign inner_eff = sop ? '0 : inner_pos;
  assign chan_eff  = sop ? '0 : chan_pos;
  assign outer_eff = sop ? '0 : outer_pos;

  assign chan = chan_eff;
  assign last = (inner_eff >= limits.nin_m1) && (chan_eff >= limits.nch_m1) &&
                (outer_eff >= limits.nout_m1);

  // Advance in memory order: inner, then channel, then outer slice
  always_comb begin
    inner_next = inner_pos;
    chan_next  = chan_pos;
    outer_next = outer_pos;
    if (accept) begin
      inner_next = inner_eff;
      chan_next  = chan_eff;
      outer_next = outer_eff;
      if (step) begin
        if (last) begin
          inner_next = '0;
          chan_next  = '0;
          outer_next = '0;
        end else if (inner_eff < limits.nin_m1) begin
          inner_next = inner_eff + 1'b1;
        end else begin
          inner_next = '0;
          if (chan_eff < limits.nch_m1) begin
            chan_next = chan_eff + 1'b1;
          end else begin
            chan_next  = '0;
            outer_next = outer_eff + 1'b1;
          end
        end
      end
    end
  end

  // One restoring remainder step per cycle
  assign red_trial   = {red_rem, red_div[CH_W-1]};
  assign red_divisor = {1'b0, limits.nch_m1} + 1'b1;
  assign red_step    = (red_trial >= red_divisor) ? (red_trial - red_divisor) : red_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_pos <= '0;
      chan_pos  <= '0;
      outer_pos <= '0;
      busy      <= 1'b0;
    end else begin
      inner_pos <= inner_next;
      outer_pos <= outer_next;
      if (reduce_start) begin
        busy     <= 1'b1;
        chan_pos <= chan_next;
      end else if (busy && (red_cnt == CNT_LAST)) begin
        busy     <= 1'b0;
        chan_pos <= red_step[CH_W-1:0];
      end else begin
        chan_pos <= chan_next;
      end
    end
  end

  // Remainder datapath
  always_ff @(posedge clk) begin
    if (reduce_start) begin
      red_rem <= '0;
      red_div <= chan_pos;
      red_cnt <= '0;
    end else if (busy) begin
      red_rem <= red_step[CH_W-1:0];
      red_div <= {red_div[CH_W-2:0], 1'b0};
      red_cnt <= red_cnt + 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csb_accum.sv @@
// ----------------------------------------------------------------------------
// csb_accum
// Rounding and saturation of the scaled value, and saturating update of a
// channel's gradient sums.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_accum (
  input  logic                              fwd,
  input  logic                              use_bias,
  input  logic signed [csb_pkg::PROD_W-1:0] prod_a,
  input  logic signed [csb_pkg::DATA_W-1:0] bias,
  input  logic signed [csb_pkg::PROD_W-1:0] prod_xy,
  input  logic signed [csb_pkg::DATA_W-1:0] dy,
  input  csb_pkg::csb_sums_t                oper,
  output logic signed [csb_pkg::DATA_W-1:0] val,
  output logic                              val_clip,
  output csb_pkg::csb_sums_t                sums_new,
  output logic                              s_clip,
  output logic                              b_clip
);
  import csb_pkg::*;

  localparam int ACC_W = PROD_W + 2;

  logic signed [ACC_W-1:0]  bias_term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  q;
  logic [ACC_W-DATA_W:0]    q_top;
  logic signed [SG_W:0]     s_sum;
  logic signed [BG_W:0]     b_sum;

  // Bias aligned to the product's 12 extra fraction bits
  assign bias_term = {{(ACC_W - DATA_W - ROUND_SHIFT){bias[DATA_W-1]}}, bias,
                      {ROUND_SHIFT{1'b0}}};
  assign acc = ACC_W'(prod_a) + ((fwd && use_bias) ? bias_term : '0);

  // Round half up, then clip to the data range
  assign rnd   = acc + ACC_W'(ROUND_HALF);
  assign q     = rnd >>> ROUND_SHIFT;
  assign q_top = q[ACC_W-1:DATA_W-1];
  assign val_clip = !((&q_top) || !(|q_top));
  assign val = val_clip ? (q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}})
                        : q[DATA_W-1:0];

  // Scale gradient sum
  assign s_sum  = (SG_W+1)'($signed(oper.s)) + (SG_W+1)'(prod_xy);
  assign s_clip = s_sum[SG_W] != s_sum[SG_W-1];
  assign sums_new.s = s_clip ? (s_sum[SG_W] ? {1'b1, {(SG_W-1){1'b0}}}
                                            : {1'b0, {(SG_W-1){1'b1}}})
                             : s_sum[SG_W-1:0];

  // Bias gradient sum, held when bias is off
  assign b_sum  = (BG_W+1)'($signed(oper.b)) + (BG_W+1)'(dy);
  assign b_clip = use_bias && (b_sum[BG_W] != b_sum[BG_W-1]);
  always_comb begin
    if (!use_bias) begin
      sums_new.b = oper.b;
    end else if (b_clip) begin
      sums_new.b = b_sum[BG_W] ? {1'b1, {(BG_W-1){1'b0}}} : {1'b0, {(BG_W-1){1'b1}}};
    end else begin
      sums_new.b = b_sum[BG_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/csb_out_fifo.sv @@
// ----------------------------------------------------------------------------
// csb_out_fifo
// Small result queue that decouples the free-running pipeline from the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module csb_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  csb_pkg::csb_result_t               push_data,
  input  logic                               pop,
  output csb_pkg::csb_result_t               head,
  output logic                               not_empty,
  output logic [csb_pkg::OUT_CNT_W-1:0]      count
);
  import csb_pkg::*;

  csb_result_t          entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/channel_scale_bias_with_gradients.sv @@
// ----------------------------------------------------------------------------
// channel_scale_bias_with_gradients
// Per-channel fixed-point scale and bias with input-gradient output and
// per-channel accumulation of scale and bias gradients.
//
//   port group   handshake               carries
//   -----------  ----------------------  -----------------------------------
//   item         item_valid/item_stall   op, start_of_pass, channel, x, dy,
//                                        scale and bias load data
//   result       result_valid/stall      value, gradient sums, channel, flags
//   cfg          cfg_valid/cfg_ready     register index and write data
//
// One item per cycle while item_stall is low. Each item passes the table
// and sum RAM read, multiply, then round/accumulate and write-back into the
// four-entry result queue. Back-to-back items on one channel are served by
// forwarding the last two sum write-backs. item_stall rises only when the
// result queue plus items in flight would exceed four, and while the channel
// position is folded into the new count after a channel_count write. Reset
// needs no clearing pass: the sum valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_scale_bias_with_gradients (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          op,
  input  logic                                start_of_pass,
  input  logic [csb_pkg::CH_W-1:0]            channel_index,
  input  logic signed [csb_pkg::DATA_W-1:0]   data_value,
  input  logic signed [csb_pkg::DATA_W-1:0]   grad_value,
  input  logic signed [csb_pkg::DATA_W-1:0]   scale_value,
  input  logic signed [csb_pkg::DATA_W-1:0]   bias_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [csb_pkg::DATA_W-1:0]   out_value,
  output logic signed [csb_pkg::SG_W-1:0]     scale_grad,
  output logic signed [csb_pkg::BG_W-1:0]     bias_grad,
  output logic [csb_pkg::CH_W-1:0]            channel_out,
  output logic                                last_of_pass,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import csb_pkg::*;

  localparam int SUM_W = SG_W + BG_W;
  localparam int TAB_W = 2 * DATA_W;

  // Configuration registers
  logic [CC_W-1:0]   cfg_channel_count;
  logic [SIZE_W-1:0] cfg_inner_size;
  logic [SIZE_W-1:0] cfg_outer_count;
  logic              cfg_use_bias;
  logic              cfg_param_grad;
  logic              cfg_input_grad;
  logic              cfg_wr;
  logic              reduce_start;
  csb_limits_t       limits;

  // Accept stage
  csb_op_t           op_in;
  logic              accept;
  logic              is_fwd, is_bwd, is_read, is_step, emits;
  logic [CH_W-1:0]   chan;
  logic              last;
  logic              busy;
  logic [CH_W-1:0]   sum_addr;
  logic [CHANNELS-1:0] sum_valid, sum_valid_next;
  logic              sv_rd;
  logic [OUT_CNT_W-1:0] pending;
  logic [OUT_CNT_W-1:0] fifo_count;

  // RAM ports
  logic [TAB_W-1:0]  tab_rdata;
  logic [SUM_W-1:0]  sum_rdata;
  logic              sum_wr_en;
  csb_sums_t         sum_wr_data;

  // Stage 1
  logic              s1_valid, s1_res;
  csb_op_t           s1_op;
  logic [CH_W-1:0]   s1_ch;
  logic              s1_last;
  logic signed [DATA_W-1:0] s1_x, s1_dy;
  logic              s1_sv;
  logic signed [DATA_W-1:0] tab_scale, tab_bias, mul_in;
  logic signed [PROD_W-1:0] prod_a, prod_xy;
  csb_sums_t         s1_oper;

  // Stage 2
  logic              s2_valid, s2_res;
  csb_op_t           s2_op;
  logic [CH_W-1:0]   s2_ch;
  logic              s2_last;
  logic signed [PROD_W-1:0] s2_prod_a, s2_prod_xy;
  logic signed [DATA_W-1:0] s2_bias, s2_dy;
  logic              s2_sv;
  csb_sums_t         s2_sum;
  csb_sums_t         s2_oper;
  logic signed [DATA_W-1:0] val;
  logic              val_clip, s_clip, b_clip;
  csb_sums_t         sums_new;

  // Last write-back, for forwarding
  logic              wb_valid;
  logic [CH_W-1:0]   wb_ch;
  csb_sums_t         wb_data;

  csb_result_t       res;
  csb_result_t       head;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;
  assign reduce_start = cfg_wr && (csb_reg_t'(cfg_index) == REG_CHANNEL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_channel_count <= CC_W'(1);
      cfg_inner_size    <= SIZE_W'(1);
      cfg_outer_count   <= SIZE_W'(1);
      cfg_use_bias      <= 1'b0;
      cfg_param_grad    <= 1'b1;
      cfg_input_grad    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (csb_reg_t'(cfg_index))
        REG_CHANNEL_COUNT: cfg_channel_count <= cfg_data[CC_W-1:0];
        REG_INNER_SIZE:    cfg_inner_size    <= cfg_data[SIZE_W-1:0];
        REG_OUTER_COUNT:   cfg_outer_count   <= cfg_data[SIZE_W-1:0];
        REG_USE_BIAS:      cfg_use_bias      <= cfg_data[0];
        REG_PARAM_GRAD:    cfg_param_grad    <= cfg_data[0];
        REG_INPUT_GRAD:    cfg_input_grad    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Clamp sizes and convert to last positions
  always_comb begin
    if (cfg_channel_count == '0) begin
      limits.nch_m1 = '0;
    end else if (cfg_channel_count[CC_W-1]) begin
      limits.nch_m1 = '1;
    end else begin
      limits.nch_m1 = cfg_channel_count[CH_W-1:0] - 1'b1;
    end
    if (cfg_inner_size == '0) begin
      limits.nin_m1 = '0;
    end else if (cfg_inner_size[SIZE_W-1]) begin
      limits.nin_m1 = '1;
    end else begin
      limits.nin_m1 = cfg_inner_size[POS_W-1:0] - 1'b1;
    end
    if (cfg_outer_count == '0) begin
      limits.nout_m1 = '0;
    end else if (cfg_outer_count[SIZE_W-1]) begin
      limits.nout_m1 = '1;
    end else begin
      limits.nout_m1 = cfg_outer_count[POS_W-1:0] - 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage
  // --------------------------------------------------------------------------
  assign op_in   = csb_op_t'(op);
  assign is_fwd  = op_in == OP_FORWARD;
  assign is_bwd  = op_in == OP_BACKWARD;
  assign is_read = op_in == OP_READ;
  assign is_step = is_fwd || is_bwd;
  assign emits   = is_fwd || is_read || (is_bwd && cfg_input_grad);

  // Hold items while the channel position is folded or when the result queue could overflow
  assign pending    = fifo_count + OUT_CNT_W'(s1_res) + OUT_CNT_W'(s2_res);
  assign item_stall = busy || (pending >= OUT_CNT_W'(OUT_DEPTH));
  assign accept     = item_valid && !item_stall;

  csb_position u_position (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sop          (start_of_pass),
    .step         (is_step),
    .reduce_start (reduce_start),
    .limits       (limits),
    .chan         (chan),
    .last         (last),
    .busy         (busy)
  );

  // Scale and bias table
  csb_ram #(.DEPTH(CHANNELS), .WIDTH(TAB_W)) u_table_ram (
    .clk     (clk),
    .wr_en   (accept && (op_in == OP_LOAD)),
    .wr_addr (channel_index),
    .wr_data ({scale_value, bias_value}),
    .rd_en   (accept),
    .rd_addr (chan),
    .rd_data (tab_rdata)
  );

  // Gradient sums
  assign sum_addr = is_read ? channel_index : chan;

  csb_ram #(.DEPTH(CHANNELS), .WIDTH(SUM_W)) u_sum_ram (
    .clk     (clk),
    .wr_en   (sum_wr_en),
    .wr_addr (s2_ch),
    .wr_data (sum_wr_data),
    .rd_en   (accept),
    .rd_addr (sum_addr),
    .rd_data (sum_rdata)
  );

  // Sum valid bits: clear on backward start of pass, set by accumulation
  assign sv_rd = (is_bwd && start_of_pass) ? 1'b0 : sum_valid[sum_addr];

  always_comb begin
    sum_valid_next = sum_valid;
    if (accept && is_bwd) begin
      if (start_of_pass) begin
        sum_valid_next = '0;
      end
      if (cfg_param_grad) begin
        sum_valid_next[chan] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= '0;
    end else begin
      sum_valid <= sum_valid_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: multiply, forward the write-back two items ahead
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_res   <= 1'b0;
    end else begin
      s1_valid <= accept && (op_in != OP_LOAD);
      s1_res   <= accept && emits;
    end
  end

  always_ff @(posedge clk) begin
    s1_op   <= op_in;
    s1_ch   <= sum_addr;
    s1_last <= last;
    s1_x    <= data_value;
    s1_dy   <= grad_value;
    s1_sv   <= sv_rd;
  end

  assign tab_scale = tab_rdata[TAB_W-1:DATA_W];
  assign tab_bias  = tab_rdata[DATA_W-1:0];
  assign mul_in    = (s1_op == OP_FORWARD) ? s1_x : s1_dy;
  assign prod_a    = tab_scale * mul_in;
  assign prod_xy   = s1_dy * s1_x;

  always_comb begin
    if (!s1_sv) begin
      s1_oper = '0;
    end else if (wb_valid && (wb_ch == s1_ch)) begin
      s1_oper = wb_data;
    end else begin
      s1_oper = sum_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: round, accumulate, write back, forward the item just ahead
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_res   <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s2_res   <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    s2_op      <= s1_op;
    s2_ch      <= s1_ch;
    s2_last    <= s1_last;
    s2_prod_a  <= prod_a;
    s2_prod_xy <= prod_xy;
    s2_bias    <= tab_bias;
    s2_dy      <= s1_dy;
    s2_sv      <= s1_sv;
    s2_sum     <= s1_oper;
  end

  assign s2_oper = (s2_sv && wb_valid && (wb_ch == s2_ch)) ? wb_data : s2_sum;

  csb_accum u_accum (
    .fwd      (s2_op == OP_FORWARD),
    .use_bias (cfg_use_bias),
    .prod_a   (s2_prod_a),
    .bias     (s2_bias),
    .prod_xy  (s2_prod_xy),
    .dy       (s2_dy),
    .oper     (s2_oper),
    .val      (val),
    .val_clip (val_clip),
    .sums_new (sums_new),
    .s_clip   (s_clip),
    .b_clip   (b_clip)
  );

  assign sum_wr_en   = s2_valid && (s2_op == OP_BACKWARD) && cfg_param_grad;
  assign sum_wr_data = sums_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= sum_wr_en;
    end
  end

  always_ff @(posedge clk) begin
    wb_ch   <= s2_ch;
    wb_data <= sum_wr_data;
  end

  // Build the result item
  always_comb begin
    res = '0;
    res.channel_out = s2_ch;
    case (s2_op)
      OP_FORWARD: begin
        res.out_value    = val;
        res.last_of_pass = s2_last;
        res.saturated    = val_clip;
      end
      OP_BACKWARD: begin
        res.out_value    = val;
        res.last_of_pass = s2_last;
        if (cfg_param_grad) begin
          res.scale_grad = sums_new.s;
          res.bias_grad  = sums_new.b;
          res.saturated  = val_clip || s_clip || b_clip;
        end else begin
          res.scale_grad = s2_oper.s;
          res.bias_grad  = s2_oper.b;
          res.saturated  = val_clip;
        end
      end
      OP_READ: begin
        res.scale_grad = s2_oper.s;
        res.bias_grad  = s2_oper.b;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  csb_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_res),
    .push_data (res),
    .pop       (result_valid && !result_stall),
    .head      (head),
    .not_empty (result_valid),
    .count     (fifo_count)
  );

  assign out_value    = head.out_value;
  assign scale_grad   = head.scale_grad;
  assign bias_grad    = head.bias_grad;
  assign channel_out  = head.channel_out;
  assign last_of_pass = head.last_of_pass;
  assign saturated    = head.saturated;

endmodule

`default_nettype wire
